FILE: src/wmpc_pkg.sv
package wmpc_pkg;

  // Fixed field widths of the two channels and the configuration port
  localparam int BYTE_W      = 8;
  localparam int OUT_SCORE_W = 32;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 3;
  localparam int LEN_NIBBLE_W = 4;
  localparam int PATTERN_SLOTS = 4;

  // ASCII case folding bounds
  localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [BYTE_W-1:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'h20;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PATTERN_A = 3'd0,
    CFG_PATTERN_B = 3'd1,
    CFG_PATTERN_C = 3'd2,
    CFG_PATTERN_D = 3'd3,
    CFG_LENGTHS   = 3'd4,
    CFG_NEGATIVE  = 3'd5
  } cfg_reg_t;

  // Input item
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } in_t;

  // Result item
  typedef struct packed {
    logic signed [OUT_SCORE_W-1:0] score;
    logic                          saturated;
  } out_t;

  // Fold 'a'..'z' onto 'A'..'Z', pass every other byte unchanged
  function automatic logic [BYTE_W-1:0] to_upper(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] r;
    r = c;
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      r = c - CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

FILE: src/weighted_multi_pattern_counter_top.sv
// Channel  | Ports                          | Direction | Moves
// ---------+--------------------------------+-----------+-----------------------------
// input    | in_valid, in_stall, in_data    | in        | one file byte per transfer
// result   | out_valid, out_stall, out_data | out       | score of a file on its last byte
// config   | cfg_wr_en, cfg_index, cfg_wdata| in        | one register write per cycle
//
// One byte per cycle unless a stalled result holds a closing byte. A byte reaches the
// scoring stage in the cycle after transfer; out_data is loaded in the cycle after that.
// The score, fill count and byte window are registered and fed back in the scoring stage.
// rst_n is synchronous, active low; it resets all but the byte, window and result data.
// A stalled result holds the scoring stage only when the byte waiting there closes a file.
module weighted_multi_pattern_counter_top
  import wmpc_pkg::*;
#(
  parameter int NUM_PATTERNS = 4,
  parameter int MAX_LEN      = 8,
  parameter int SCORE_WIDTH  = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_t                    in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_t                   out_data,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int WIN_D = (MAX_LEN > 1) ? MAX_LEN - 1 : 1;
  localparam int FW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LW    = $clog2(MAX_LEN + 1);

  // Configuration
  logic [NUM_PATTERNS-1:0][MAX_LEN-1:0][BYTE_W-1:0] pat_r, pat_nxt;
  logic [NUM_PATTERNS-1:0][LW-1:0]                  len_r, len_nxt;
  logic [NUM_PATTERNS-1:0]                          neg_r, neg_nxt;

  // Input register
  logic              s_valid_r, s_valid_nxt;
  logic [BYTE_W-1:0] s_byte_r, s_byte_nxt;
  logic              s_last_r, s_last_nxt;

  // Per-file state
  logic [WIN_D-1:0][BYTE_W-1:0] win_r, win_nxt;
  logic [FW-1:0]                fill_r, fill_nxt;
  logic signed [SCORE_WIDTH-1:0] score_r, score_nxt;
  logic                         clip_r, clip_nxt;

  // Result register
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;

  logic                          out_free;
  logic                          s_adv;
  logic                          in_fire;
  logic [NUM_PATTERNS-1:0]       hits;
  logic signed [SCORE_WIDTH-1:0] score_new;
  logic                          clip_new;
  logic [LEN_NIBBLE_W-1:0]       nib;

  // Handshake
  assign out_free = !out_valid_r || !out_stall;
  assign s_adv    = s_valid_r && (!s_last_r || out_free);
  assign in_stall = s_valid_r && !s_adv;
  assign in_fire  = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  wmpc_match #(
    .NUM_PATTERNS (NUM_PATTERNS),
    .MAX_LEN      (MAX_LEN)
  ) u_match (
    .cur_byte (s_byte_r),
    .window   (win_r),
    .fill     (fill_r),
    .patterns (pat_r),
    .lengths  (len_r),
    .hits     (hits)
  );

  wmpc_score #(
    .NUM_PATTERNS (NUM_PATTERNS),
    .SCORE_WIDTH  (SCORE_WIDTH)
  ) u_score (
    .score_i  (score_r),
    .hits     (hits),
    .negative (neg_r),
    .score_o  (score_new),
    .clip_o   (clip_new)
  );

  // Register writes: fold pattern case and clamp lengths on the way in
  always_comb begin
    pat_nxt = pat_r;
    len_nxt = len_r;
    neg_nxt = neg_r;
    nib     = '0;
    if (cfg_wr_en) begin
      for (int p = 0; p < NUM_PATTERNS; p++) begin
        if (cfg_index == CFG_INDEX_W'(CFG_PATTERN_A) + CFG_INDEX_W'(p)) begin
          for (int k = 0; k < MAX_LEN; k++) begin
            pat_nxt[p][k] = to_upper(cfg_wdata[BYTE_W*k +: BYTE_W]);
          end
        end
      end
      case (cfg_index)
        CFG_LENGTHS: begin
          for (int p = 0; p < NUM_PATTERNS; p++) begin
            nib = cfg_wdata[LEN_NIBBLE_W*p +: LEN_NIBBLE_W];
            if (nib > LEN_NIBBLE_W'(MAX_LEN)) begin
              len_nxt[p] = LW'(MAX_LEN);
            end else begin
              len_nxt[p] = LW'(nib);
            end
          end
        end
        CFG_NEGATIVE: begin
          neg_nxt = cfg_wdata[NUM_PATTERNS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Capture the next byte, already case-folded
  always_comb begin
    s_valid_nxt = s_valid_r;
    s_byte_nxt  = s_byte_r;
    s_last_nxt  = s_last_r;
    if (in_fire) begin
      s_valid_nxt = 1'b1;
      s_byte_nxt  = to_upper(in_data.data_byte);
      s_last_nxt  = in_data.last_byte;
    end else if (s_adv) begin
      s_valid_nxt = 1'b0;
    end
  end

  // Score the staged byte; close the file on its last byte
  always_comb begin
    win_nxt       = win_r;
    fill_nxt      = fill_r;
    score_nxt     = score_r;
    clip_nxt      = clip_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (s_adv) begin
      if (s_last_r) begin
        out_valid_nxt          = 1'b1;
        out_data_nxt.score     = OUT_SCORE_W'(score_new);
        out_data_nxt.saturated = clip_r || clip_new;
        fill_nxt               = '0;
        score_nxt              = '0;
        clip_nxt               = 1'b0;
      end else begin
        score_nxt = score_new;
        clip_nxt  = clip_r || clip_new;
        win_nxt[0] = s_byte_r;
        for (int i = 1; i < WIN_D; i++) begin
          win_nxt[i] = win_r[i-1];
        end
        if (fill_r < FW'(MAX_LEN - 1)) begin
          fill_nxt = fill_r + FW'(1);
        end
      end
    end
  end

  // Control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r       <= '0;
      len_r       <= '0;
      neg_r       <= '0;
      s_valid_r   <= 1'b0;
      fill_r      <= '0;
      score_r     <= '0;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pat_r       <= pat_nxt;
      len_r       <= len_nxt;
      neg_r       <= neg_nxt;
      s_valid_r   <= s_valid_nxt;
      fill_r      <= fill_nxt;
      score_r     <= score_nxt;
      clip_r      <= clip_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    s_byte_r   <= s_byte_nxt;
    s_last_r   <= s_last_nxt;
    win_r      <= win_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

FILE: src/wmpc_match.sv
module wmpc_match
  import wmpc_pkg::*;
#(
  parameter int NUM_PATTERNS = 4,
  parameter int MAX_LEN      = 8
) (
  input  logic [BYTE_W-1:0]                                cur_byte,
  input  logic [((MAX_LEN > 1) ? MAX_LEN-1 : 1)-1:0][BYTE_W-1:0] window,
  input  logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0]  fill,
  input  logic [NUM_PATTERNS-1:0][MAX_LEN-1:0][BYTE_W-1:0] patterns,
  input  logic [NUM_PATTERNS-1:0][$clog2(MAX_LEN+1)-1:0]   lengths,
  output logic [NUM_PATTERNS-1:0]                          hits
);

  localparam int LW = $clog2(MAX_LEN + 1);

  logic [MAX_LEN-1:0][BYTE_W-1:0] hist;
  logic [LW-1:0]                  avail;

  // Line up the current byte and the bytes before it, newest first
  always_comb begin
    hist[0] = cur_byte;
    for (int b = 1; b < MAX_LEN; b++) begin
      hist[b] = window[b-1];
    end
  end

  // Bytes of the current file that a match may span
  assign avail = LW'(fill) + LW'(1);

  // Compare every pattern at every length, then pick the configured one
  always_comb begin
    logic m;
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      hits[p] = 1'b0;
      for (int l = 1; l <= MAX_LEN; l++) begin
        m = 1'b1;
        for (int k = 0; k < l; k++) begin
          if (patterns[p][k] != hist[l-1-k]) begin
            m = 1'b0;
          end
        end
        if (lengths[p] == LW'(l) && avail >= LW'(l) && m) begin
          hits[p] = 1'b1;
        end
      end
    end
  end

endmodule

FILE: src/wmpc_score.sv
module wmpc_score
  import wmpc_pkg::*;
#(
  parameter int NUM_PATTERNS = 4,
  parameter int SCORE_WIDTH  = 32
) (
  input  logic signed [SCORE_WIDTH-1:0] score_i,
  input  logic [NUM_PATTERNS-1:0]       hits,
  input  logic [NUM_PATTERNS-1:0]       negative,
  output logic signed [SCORE_WIDTH-1:0] score_o,
  output logic                          clip_o
);

  localparam int SW = SCORE_WIDTH;
  localparam int HW = $clog2(2 * NUM_PATTERNS);
  localparam logic signed [SW-1:0] SC_MAX  = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SC_MIN  = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [SW-1:0] NEAR_HI = SC_MAX - SW'(NUM_PATTERNS);
  localparam logic signed [SW-1:0] NEAR_LO = SC_MIN + SW'(NUM_PATTERNS);

  logic              near_hi;
  logic              near_lo;
  logic [HW-1:0]     head;
  logic [HW-1:0]     foot;
  logic signed [HW:0] delta;
  logic              clip_hi;
  logic              clip_lo;

  // Within NUM_PATTERNS of a limit the steps can clip; elsewhere they just add
  assign near_hi = score_i > NEAR_HI;
  assign near_lo = score_i < NEAR_LO;

  // Walk the hits in pattern order on small distances to each limit
  always_comb begin
    head    = HW'(SC_MAX - score_i);
    foot    = HW'(score_i - SC_MIN);
    delta   = '0;
    clip_hi = 1'b0;
    clip_lo = 1'b0;
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      if (hits[p]) begin
        if (negative[p]) begin
          delta = delta - (HW+1)'(1);
          head  = head + HW'(1);
          if (foot == '0) begin
            clip_lo = 1'b1;
          end else begin
            foot = foot - HW'(1);
          end
        end else begin
          delta = delta + (HW+1)'(1);
          foot  = foot + HW'(1);
          if (head == '0) begin
            clip_hi = 1'b1;
          end else begin
            head = head - HW'(1);
          end
        end
      end
    end
  end

  // Select the new score from the region the old one sat in
  always_comb begin
    if (near_hi) begin
      score_o = SC_MAX - SW'(head);
      clip_o  = clip_hi;
    end else if (near_lo) begin
      score_o = SC_MIN + SW'(foot);
      clip_o  = clip_lo;
    end else begin
      score_o = score_i + SW'(delta);
      clip_o  = 1'b0;
    end
  end

endmodule

FILE: test/tb_weighted_multi_pattern_counter_top.sv
module tb_weighted_multi_pattern_counter_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wmpc_pkg::*;

  localparam int SPAN_MAX      = 8;        // longest pattern the block compares
  localparam int HISTORY_DEPTH = SPAN_MAX - 1;
  localparam int SETTLE_CYCLES = 4;        // covers the input and result registers plus margin
  // About 2000 bytes, each worst case an idle gap plus a long result hold,
  // and a config pass per phase; taken several times over.
  localparam int CYCLE_LIMIT   = 400_000;
  localparam logic signed [OUT_SCORE_W-1:0] SCORE_TOP =
    {1'b0, {(OUT_SCORE_W-1){1'b1}}};
  localparam logic signed [OUT_SCORE_W-1:0] SCORE_BOTTOM =
    {1'b1, {(OUT_SCORE_W-1){1'b0}}};
  // Indexes that map to no register
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_BLOCKS} rx_mode_t;
  typedef logic [BYTE_W-1:0] byte_q_t[$];

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_t                    in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_t                   out_data;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Register copies
  logic [CFG_DATA_W-1:0]                  pat_shadow [PATTERN_SLOTS] = '{default: '0};
  logic [PATTERN_SLOTS*LEN_NIBBLE_W-1:0]  len_shadow = '0;
  logic [PATTERN_SLOTS-1:0]               neg_shadow = '0;

  // Per-file scan state
  logic [BYTE_W-1:0]               history [HISTORY_DEPTH] = '{default: '0};
  int unsigned                     filled = 0;
  logic signed [OUT_SCORE_W-1:0]   file_score = '0;
  logic                            file_clipped = 1'b0;
  out_t                            file_scores_due[$];

  int       mismatches = 0;
  int       cycle_count = 0;
  int       burst_left = 0;
  bit       steady_sender = 1'b0;
  rx_mode_t rx_mode = RX_FREE;
  int       rx_phase_left = 0;

  weighted_multi_pattern_counter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result stall pattern: free, light, heavy and long blocked stretches
  always @(posedge clk) begin
    if (rx_phase_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_phase_left = $urandom_range(8, 80);
    end
    rx_phase_left--;
    case (rx_mode)
      RX_FREE:  out_stall <= 1'b0;
      RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      RX_HEAVY: out_stall <= ($urandom_range(0, 1) == 0);
      default:  out_stall <= ((rx_phase_left % 12) < 9);
    endcase
  end

  // ASCII uppercase; other byte values pass through
  function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
    if (c >= "a" && c <= "z") return c & 8'hdf;
    return c;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pack_pattern(input string s);
    logic [CFG_DATA_W-1:0] r;
    r = '0;
    for (int i = 0; i < s.len() && i < SPAN_MAX; i++) r[8*i +: 8] = s[i];
    return r;
  endfunction

  function automatic void apply_reg_write(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_PATTERN_A, CFG_PATTERN_B, CFG_PATTERN_C, CFG_PATTERN_D: begin
        pat_shadow[idx[1:0]] = data;
      end
      CFG_LENGTHS:  len_shadow = data[PATTERN_SLOTS*LEN_NIBBLE_W-1:0];
      CFG_NEGATIVE: neg_shadow = data[PATTERN_SLOTS-1:0];
      default: ;
    endcase
  endfunction

  // Saturating +1 / -1 on the file score
  function automatic void bump_score(input bit up);
    if (up) begin
      if (file_score == SCORE_TOP) file_clipped = 1'b1;
      else file_score = file_score + 1;
    end else begin
      if (file_score == SCORE_BOTTOM) file_clipped = 1'b1;
      else file_score = file_score - 1;
    end
  endfunction

  // Does pattern p end at byte cur, wholly inside the current file?
  function automatic bit pattern_ends_here(input int p, input logic [BYTE_W-1:0] cur);
    int unsigned width;
    int unsigned back;
    logic [BYTE_W-1:0] want;
    logic [BYTE_W-1:0] seen;
    width = len_shadow[LEN_NIBBLE_W*p +: LEN_NIBBLE_W];
    if (width == 0) return 1'b0;
    if (width > SPAN_MAX) width = SPAN_MAX;
    if (filled + 1 < width) return 1'b0;
    for (int k = 0; k < width; k++) begin
      back = width - 1 - k;
      want = fold_case(pat_shadow[p][8*k +: 8]);
      seen = (back == 0) ? cur : history[back-1];
      if (want != seen) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Advance the scan by one accepted byte; queue the score when the file closes
  function automatic void predict_byte(input in_t item);
    logic [BYTE_W-1:0] cur;
    out_t result;
    cur = fold_case(item.data_byte);
    for (int p = 0; p < PATTERN_SLOTS; p++) begin
      if (pattern_ends_here(p, cur)) bump_score(!neg_shadow[p]);
    end
    if (item.last_byte) begin
      result.score = file_score;
      result.saturated = file_clipped;
      file_scores_due.push_back(result);
      history = '{default: '0};
      filled = 0;
      file_score = '0;
      file_clipped = 1'b0;
    end else begin
      for (int i = HISTORY_DEPTH - 1; i > 0; i--) history[i] = history[i-1];
      history[0] = cur;
      if (filled < HISTORY_DEPTH) filled++;
    end
  endfunction

  function automatic void log_mismatch(input string field, input logic signed [63:0] want,
                                       input logic signed [63:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch on %s: expected %0d, got %0d", field, want, got);
    end
  endfunction

  // Compare each result transfer with the oldest queued file score
  always @(posedge clk) begin : result_check
    out_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (file_scores_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: score %0d saturated %0b",
                   out_data.score, out_data.saturated);
        end
      end else begin
        due = file_scores_due.pop_front();
        if (out_data.score !== due.score) log_mismatch("score", due.score, out_data.score);
        if (out_data.saturated !== due.saturated) begin
          log_mismatch("saturated", due.saturated, out_data.saturated);
        end
      end
    end
  end

  // Offer one byte; bursts of random length with random gaps between them
  task automatic send_byte(input logic [BYTE_W-1:0] value, input bit closes);
    int gap;
    in_t item;
    item.data_byte = value;
    item.last_byte = closes;
    if (burst_left == 0) begin
      gap = (steady_sender || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(item);
    burst_left--;
  endtask

  task automatic send_bytes(input byte_q_t bytes, input bit closes_file = 1'b1);
    foreach (bytes[i]) send_byte(bytes[i], closes_file && (i == bytes.size() - 1));
  endtask

  task automatic send_text(input string s, input bit closes_file = 1'b1);
    byte_q_t bytes;
    for (int i = 0; i < s.len(); i++) bytes.push_back(s[i]);
    send_bytes(bytes, closes_file);
  endtask

  // Hold the input until every queued score has come, then let the pipe empty
  task automatic drain_results();
    in_valid <= 1'b0;
    while (file_scores_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    apply_reg_write(idx, data);
  endtask

  // Program all registers; junk above the used bits of the narrow ones
  task automatic configure(input logic [CFG_DATA_W-1:0] pa, input logic [CFG_DATA_W-1:0] pb,
                           input logic [CFG_DATA_W-1:0] pc, input logic [CFG_DATA_W-1:0] pd,
                           input logic [15:0] lens, input logic [3:0] neg);
    logic [CFG_DATA_W-1:0] junk;
    junk = {32'($urandom), 32'($urandom)};
    drain_results();
    write_reg(CFG_PATTERN_A, pa);
    write_reg(CFG_PATTERN_B, pb);
    write_reg(CFG_PATTERN_C, pc);
    write_reg(CFG_PATTERN_D, pd);
    write_reg(CFG_LENGTHS, {junk[63:16], lens});
    write_reg(CFG_NEGATIVE, {junk[63:4], neg});
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [BYTE_W-1:0] vary_case(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] low;
    low = c | 8'h20;
    if (low >= "a" && low <= "z" && $urandom_range(0, 1) == 1) return c ^ 8'h20;
    return c;
  endfunction

  // Patterns over a small alphabet so that files hit them often
  function automatic logic [CFG_DATA_W-1:0] rand_pattern();
    logic [CFG_DATA_W-1:0] r;
    int pick;
    for (int k = 0; k < SPAN_MAX; k++) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) r[8*k +: 8] = vary_case("a");
      else if (pick < 6) r[8*k +: 8] = vary_case("b");
      else if (pick < 7) r[8*k +: 8] = 8'h00;
      else if (pick < 8) r[8*k +: 8] = 8'hff;
      else r[8*k +: 8] = 8'($urandom_range(0, 255));
    end
    return r;
  endfunction

  // Send files built from pattern copies, pattern bytes and noise
  task automatic random_phase(input logic [CFG_DATA_W-1:0] pa, input logic [CFG_DATA_W-1:0] pb,
                              input logic [CFG_DATA_W-1:0] pc, input logic [CFG_DATA_W-1:0] pd,
                              input logic [15:0] lens, input logic [3:0] neg,
                              input int budget, input bit steady);
    byte_q_t file_bytes;
    int sent;
    int target;
    int pick;
    int p;
    int span;
    configure(pa, pb, pc, pd, lens, neg);
    steady_sender = steady;
    sent = 0;
    while (sent < budget) begin
      file_bytes.delete();
      pick = $urandom_range(0, 9);
      target = (pick == 0) ? 1 : (pick < 7) ? $urandom_range(2, 20) : $urandom_range(21, 60);
      while (file_bytes.size() < target) begin
        pick = $urandom_range(0, 99);
        p = $urandom_range(0, PATTERN_SLOTS - 1);
        if (pick < 45) begin
          // whole pattern, or a broken prefix of it
          span = len_shadow[LEN_NIBBLE_W*p +: LEN_NIBBLE_W];
          if (span == 0 || span > SPAN_MAX) span = SPAN_MAX;
          if ($urandom_range(0, 3) == 0) span = $urandom_range(1, span);
          for (int k = 0; k < span; k++) begin
            file_bytes.push_back(vary_case(pat_shadow[p][8*k +: 8]));
          end
        end else if (pick < 80) begin
          file_bytes.push_back(vary_case(pat_shadow[p][8*$urandom_range(0, SPAN_MAX-1) +: 8]));
        end else begin
          file_bytes.push_back(8'($urandom_range(0, 255)));
        end
      end
      while (file_bytes.size() > target) void'(file_bytes.pop_back());
      send_bytes(file_bytes);
      sent += target;
    end
    steady_sender = 1'b0;
  endtask

  // Reset values: every pattern disabled, all scores zero
  task automatic test_reset_state();
    send_byte("a", 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
  endtask

  // Case folding, overlaps, negative weight, file edge, length clamp
  task automatic test_directed_matching();
    configure(pack_pattern("abc"), pack_pattern("AA"), 64'h0000_0000_0000_ff00,
              pack_pattern("ZZZZZZZZ"), 16'hf223, 4'b1010);
    send_text("xAbCaBc");
    send_text("aAa");
    send_text("ab");
    send_text("c");
    send_bytes('{8'h00, 8'hff});
    send_text("`{@[zZ");
    send_text("zzzzzzzzz");
  endtask

  // A register write between two bytes of one file applies from the next byte
  task automatic test_midfile_write();
    configure(pack_pattern("abc"), '0, '0, '0, 16'h0003, 4'b0000);
    send_text("ab", 1'b0);
    drain_results();
    write_reg(CFG_NEGATIVE, 64'h1);
    cfg_wr_en <= 1'b0;
    send_text("c");
  endtask

  // Writes to unmapped indexes change nothing
  task automatic test_unknown_index();
    drain_results();
    write_reg(CFG_SPARE_LO, '1);
    write_reg(CFG_SPARE_HI, '1);
    cfg_wr_en <= 1'b0;
    send_text("abcABC");
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < 5; i++) begin
      random_phase(rand_pattern(), rand_pattern(), rand_pattern(), rand_pattern(),
                   16'($urandom), 4'($urandom), 200, i == 2);
    end
    random_phase('1, '1, '1, '1, 16'hffff, 4'hf, 200, 1'b0);
    random_phase('0, '0, '0, '0, 16'h1111, 4'h0, 200, 1'b1);
    random_phase(rand_pattern(), rand_pattern(), rand_pattern(), rand_pattern(),
                 16'h8888, 4'h5, 200, 1'b0);
    random_phase(rand_pattern(), rand_pattern(), rand_pattern(), rand_pattern(),
                 16'h0000, 4'hf, 150, 1'b0);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_directed_matching();
    test_midfile_write();
    test_unknown_index();
    test_random_traffic();
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && file_scores_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
